// ----- rtl/core/julia_escape_time_pixel_top_macros.svh -----
// Assertion helpers shared by the escape-time core.
`ifndef JULIA_ESCAPE_TIME_PIXEL_TOP_MACROS_SVH
`define JULIA_ESCAPE_TIME_PIXEL_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define JETP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Uses the module's own i_clk / i_rst_n.
`define JETP_ASSERT(label, prop, msg) \
    `JETP_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)
`else
`define JETP_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define JETP_ASSERT(label, prop, msg)
`endif

`endif

// ----- rtl/core/jetp_pkg.sv -----
`timescale 1ns / 1ps

package jetp_pkg;

    // Field and register widths
    localparam int WORD_W  = 32;
    localparam int STEP_W  = 31;
    localparam int DIM_W   = 13;
    localparam int LIMIT_W = 16;
    localparam int PIX_W   = 12;
    localparam int OUT_W   = 16;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Parameter defaults
    localparam int DEF_MAX_DIM    = 4096;
    localparam int DEF_FRAC_BITS  = 28;
    localparam int DEF_COUNT_BITS = 16;

    // Register map (index = paddr[4:2])
    localparam logic [2:0] REG_CONST_REAL  = 3'd0;
    localparam logic [2:0] REG_CONST_IMAG  = 3'd1;
    localparam logic [2:0] REG_CENTER_REAL = 3'd2;
    localparam logic [2:0] REG_CENTER_IMAG = 3'd3;
    localparam logic [2:0] REG_PIXEL_STEP  = 3'd4;
    localparam logic [2:0] REG_IMAGE_W     = 3'd5;
    localparam logic [2:0] REG_IMAGE_H     = 3'd6;
    localparam logic [2:0] REG_ITER_LIMIT  = 3'd7;

    localparam logic [STEP_W-1:0]  RST_PIXEL_STEP = 31'd268435;
    localparam logic [DIM_W-1:0]   RST_IMAGE_DIM  = 13'd1024;
    localparam logic [LIMIT_W-1:0] RST_ITER_LIMIT = 16'd255;

    typedef struct packed {
        logic signed [WORD_W-1:0] const_real;
        logic signed [WORD_W-1:0] const_imag;
        logic signed [WORD_W-1:0] center_real;
        logic signed [WORD_W-1:0] center_imag;
        logic [STEP_W-1:0]        pixel_step;
        logic [DIM_W-1:0]         image_width;
        logic [DIM_W-1:0]         image_height;
        logic [LIMIT_W-1:0]       iteration_limit;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_STEP,
        ST_DONE
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic capture;   // take pixel, start-point products
        logic load;      // start point into z, clear count
        logic step;      // z <= z*z + c, count++
        logic res_load;  // result into output register
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic stop;      // escaped or limit reached
        logic res_free;  // output register can take a result
    } t_sts;

endpackage

// ----- rtl/core/jetp_pix_if.sv -----
`timescale 1ns / 1ps

interface jetp_pix_if import jetp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
    logic             frame_start;

    modport source (output valid, output pixel_col, output pixel_row, output frame_start,
                    input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, input frame_start,
                    output ready);
endinterface

// ----- rtl/core/jetp_res_if.sv -----
`timescale 1ns / 1ps

interface jetp_res_if import jetp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] escape_count;
    logic [OUT_W-1:0] frame_max_count;

    modport source (output valid, output escape_count, output frame_max_count,
                    input ready);
    modport sink   (input valid, input escape_count, input frame_max_count,
                    output ready);
endinterface

// ----- rtl/core/jetp_regs.sv -----
`timescale 1ns / 1ps

module jetp_regs import jetp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg        r_cfg;
    logic        wr_en;
    logic [2:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.const_real      <= '0;
            r_cfg.const_imag      <= '0;
            r_cfg.center_real     <= '0;
            r_cfg.center_imag     <= '0;
            r_cfg.pixel_step      <= RST_PIXEL_STEP;
            r_cfg.image_width     <= RST_IMAGE_DIM;
            r_cfg.image_height    <= RST_IMAGE_DIM;
            r_cfg.iteration_limit <= RST_ITER_LIMIT;
        end else if (wr_en) begin
            unique case (idx)
                REG_CONST_REAL:  r_cfg.const_real      <= pwdata;
                REG_CONST_IMAG:  r_cfg.const_imag      <= pwdata;
                REG_CENTER_REAL: r_cfg.center_real     <= pwdata;
                REG_CENTER_IMAG: r_cfg.center_imag     <= pwdata;
                REG_PIXEL_STEP:  r_cfg.pixel_step      <= pwdata[STEP_W-1:0];
                REG_IMAGE_W:     r_cfg.image_width     <= pwdata[DIM_W-1:0];
                REG_IMAGE_H:     r_cfg.image_height    <= pwdata[DIM_W-1:0];
                REG_ITER_LIMIT:  r_cfg.iteration_limit <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_CONST_REAL:  prdata = r_cfg.const_real;
            REG_CONST_IMAG:  prdata = r_cfg.const_imag;
            REG_CENTER_REAL: prdata = r_cfg.center_real;
            REG_CENTER_IMAG: prdata = r_cfg.center_imag;
            REG_PIXEL_STEP:  prdata = DATA_W'(r_cfg.pixel_step);
            REG_IMAGE_W:     prdata = DATA_W'(r_cfg.image_width);
            REG_IMAGE_H:     prdata = DATA_W'(r_cfg.image_height);
            REG_ITER_LIMIT:  prdata = DATA_W'(r_cfg.iteration_limit);
            default:         prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/jetp_dp.sv -----
`timescale 1ns / 1ps
`include "julia_escape_time_pixel_top_macros.svh"

module jetp_dp import jetp_pkg::*; #(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic [PIX_W-1:0] i_pixel_col,
    input  logic [PIX_W-1:0] i_pixel_row,
    input  logic             i_frame_start,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             i_res_ready,
    output logic             o_res_valid,
    output logic [OUT_W-1:0] o_escape_count,
    output logic [OUT_W-1:0] o_frame_max_count
);

    localparam int OFF_W  = PIX_W + 1;
    localparam int MAP_W  = OFF_W + STEP_W + 1;
    localparam int SUM_W  = MAP_W + 1;
    localparam int SQ_W   = WORD_W - 1;
    localparam int PRD_W  = 2 * WORD_W;
    localparam logic [PRD_W-1:0] BOUND = 64'd4 << FRAC_BITS;
    localparam logic signed [PRD_W-1:0] WMAX = 64'sd2147483647;
    localparam logic signed [PRD_W-1:0] WMIN = -64'sd2147483648;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PRD_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > WMAX)      r = WMAX[WORD_W-1:0];
        else if (v < WMIN) r = WMIN[WORD_W-1:0];
        else               r = v[WORD_W-1:0];
        return r;
    endfunction

    // ---------------- start point ----------------
    logic [DIM_W-1:0]          dim_w, dim_h;
    logic signed [OFF_W-1:0]   off_re, off_im;
    logic signed [MAP_W-1:0]   map_re, map_im, step_s;
    logic signed [MAP_W-1:0]   r_map_re, r_map_im;
    logic signed [SUM_W-1:0]   start_re, start_im;
    logic                      r_fs;

    assign dim_w = (32'(i_cfg.image_width) > MAX_DIM)  ? DIM_W'(MAX_DIM) : i_cfg.image_width;
    assign dim_h = (32'(i_cfg.image_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : i_cfg.image_height;

    // halved dimension fits PIX_W bits
    assign off_re = $signed({1'b0, i_pixel_col}) - $signed({1'b0, dim_w[DIM_W-1:1]});
    assign off_im = $signed({1'b0, i_pixel_row}) - $signed({1'b0, dim_h[DIM_W-1:1]});
    assign step_s = MAP_W'($signed({1'b0, i_cfg.pixel_step}));
    assign map_re = MAP_W'(off_re) * step_s;
    assign map_im = MAP_W'(off_im) * step_s;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_map_re <= map_re;
            r_map_im <= map_im;
            r_fs     <= i_frame_start;
        end
    end

    assign start_re = SUM_W'(r_map_re) + SUM_W'(i_cfg.center_real);
    assign start_im = SUM_W'(r_map_im) + SUM_W'(i_cfg.center_imag);

    // ---------------- iteration ----------------
    logic signed [WORD_W-1:0]  r_re, r_im;
    logic [COUNT_BITS-1:0]     r_count;
    logic [COUNT_BITS-1:0]     limit;
    logic signed [PRD_W-1:0]   p_rr, p_ii, p_ri;
    logic [PRD_W-2:0]          r_prr, r_pii;
    logic signed [PRD_W-1:0]   r_pri;
    logic [PRD_W-2:0]          rr_sh, ii_sh;
    logic [SQ_W-1:0]           rr, ii;
    logic [WORD_W-1:0]         mag;
    logic                      escape;
    logic signed [WORD_W+1:0]  nre_sum;
    logic signed [PRD_W-1:0]   ri_sh, nim_sum;

    assign limit = COUNT_BITS'(i_cfg.iteration_limit);

    assign p_rr = PRD_W'(r_re) * PRD_W'(r_re);
    assign p_ii = PRD_W'(r_im) * PRD_W'(r_im);
    assign p_ri = PRD_W'(r_re) * PRD_W'(r_im);

    always_ff @(posedge i_clk) begin
        r_prr <= p_rr[PRD_W-2:0];
        r_pii <= p_ii[PRD_W-2:0];
        r_pri <= p_ri;
    end

    // truncate, then clamp to the signed word maximum
    assign rr_sh = r_prr >> FRAC_BITS;
    assign ii_sh = r_pii >> FRAC_BITS;
    assign rr    = (rr_sh > (PRD_W-1)'(WMAX)) ? {SQ_W{1'b1}} : rr_sh[SQ_W-1:0];
    assign ii    = (ii_sh > (PRD_W-1)'(WMAX)) ? {SQ_W{1'b1}} : ii_sh[SQ_W-1:0];
    assign mag   = WORD_W'(rr) + WORD_W'(ii);
    assign escape = !(PRD_W'(mag) < BOUND);

    assign nre_sum = (WORD_W+2)'($signed({1'b0, rr})) - (WORD_W+2)'($signed({1'b0, ii}))
                   + (WORD_W+2)'(i_cfg.const_real);
    // 2*re*im: arithmetic shift floors toward minus infinity
    assign ri_sh   = r_pri >>> (FRAC_BITS - 1);
    assign nim_sum = ri_sh + PRD_W'(i_cfg.const_imag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_re <= sat_word(PRD_W'(start_re));
            r_im <= sat_word(PRD_W'(start_im));
        end else if (i_cmd.step) begin
            r_re <= sat_word(PRD_W'(nre_sum));
            r_im <= sat_word(nim_sum);
        end
    end

    // ---------------- result ----------------
    logic [COUNT_BITS-1:0] r_run_max, base_max, new_max;
    logic [COUNT_BITS-1:0] r_esc, r_max_out;
    logic                  r_res_valid;

    assign base_max = r_fs ? COUNT_BITS'(1) : r_run_max;
    assign new_max  = (r_count > base_max) ? r_count : base_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_max   <= COUNT_BITS'(1);
            r_res_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_run_max   <= new_max;
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_esc     <= r_count;
            r_max_out <= new_max;
        end
    end

    assign o_sts.stop        = escape || (r_count >= limit);
    assign o_sts.res_free    = !r_res_valid || i_res_ready;
    assign o_res_valid       = r_res_valid;
    assign o_escape_count    = OUT_W'(r_esc);
    assign o_frame_max_count = OUT_W'(r_max_out);

    `JETP_ASSERT(a_count_in_limit, i_cmd.step |=> (r_count <= limit), "count passed limit")
    `JETP_ASSERT(a_max_covers_count, r_res_valid |-> (r_max_out != 0 && r_max_out >= r_esc), "frame max below count")

endmodule

// ----- rtl/core/jetp_ctrl.sv -----
`timescale 1ns / 1ps
`include "julia_escape_time_pixel_top_macros.svh"

module jetp_ctrl import jetp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = ST_MUL;
            end
            // products of z settle into their registers
            ST_MUL: begin
                n_state = ST_STEP;
            end
            ST_STEP: begin
                if (!i_sts.stop) begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_MUL;
                end else if (i_sts.res_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.res_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `JETP_ASSERT(a_load_when_free, o_cmd.res_load |-> i_sts.res_free, "result overwrote pending transfer")
    `JETP_ASSERT(a_step_loops, (r_state == ST_STEP && !i_sts.stop) |=> (r_state == ST_MUL), "iteration loop broken")
    `JETP_ASSERT(a_accept_to_load, (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_LOAD), "accepted pixel not loaded")

endmodule

// ----- rtl/core/julia_escape_time_pixel_top.sv -----
`timescale 1ns / 1ps

// Julia-set escape-time pixel engine. Each pixel transfer (column, row, frame_start)
// is mapped to z0 = (pos - dim/2) * pixel_step + center in signed Q3.28 and iterated
// as z = z*z + c until |z|^2 reaches 4 or iteration_limit is hit; the result transfer
// carries the iteration count and the running maximum of the frame (reset to 1 by
// frame_start). One pixel is processed at a time; each iteration passes through two
// states, ST_MUL for the registered squarings and ST_STEP for the escape test and z
// update. A finished result waits in the output register while the next pixel is
// accepted; if it is still unclaimed when the next one finishes, the engine stalls
// until it is. Configuration is to be written over APB only while the engine is
// idle; the user must ensure this, as the block itself does not enforce it.

module julia_escape_time_pixel_top import jetp_pkg::*; #(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    jetp_pix_if.sink          i_pix,
    jetp_res_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    jetp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    jetp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    jetp_dp #(
        .MAX_DIM    (MAX_DIM),
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_pixel_col       (i_pix.pixel_col),
        .i_pixel_row       (i_pix.pixel_row),
        .i_frame_start     (i_pix.frame_start),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_res_ready       (o_res.ready),
        .o_res_valid       (o_res.valid),
        .o_escape_count    (o_res.escape_count),
        .o_frame_max_count (o_res.frame_max_count)
    );

endmodule
